/* rtl/core/mctd_pkg.sv */
// shared types and constants of the multi-client periodic tick divider
// used by the controller, datapath and top level; no dependencies
package mctd_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int STEP_W      = 32;
    localparam int DIV_CNT_W   = $clog2(STEP_W);
    localparam int CLIENT_W    = 8;
    localparam int PERIOD_W    = 16;
    localparam int TICK_W      = 32;

    typedef enum logic [0:0] {
        REQ_PLAIN    = 1'b0,
        REQ_REGISTER = 1'b1
    } req_t;

    typedef enum logic [0:0] {
        KIND_FIRE = 1'b0,
        KIND_END  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_INSERT,
        S_FETCH,
        S_SCAN,
        S_FINISH
    } state_t;

    // one table entry; rem tracks step_count modulo period
    typedef struct packed {
        logic [CLIENT_W-1:0] client;
        logic [PERIOD_W-1:0] period;
        logic [TICK_W-1:0]   ticks;
        logic [PERIOD_W-1:0] rem;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic accept;
        logic div_init;
        logic div_step;
        logic insert;
        logic scan_adv;
        logic emit_end;
    } cmd_t;

    typedef struct packed {
        logic reg_ok;
        logic div_done;
        logic table_empty;
        logic last_entry;
        logic fire;
        logic out_free;
    } stat_t;

endpackage

/* rtl/core/multi_client_periodic_tick_divider_unit.sv */
// top level of the multi-client periodic tick divider
// depends on mctd_pkg, mctd_ctrl and mctd_dp
//
// usage:
// - the input channel (in_valid/in_ready) takes one service call per item:
//   req_type selects a plain tick or a registration of new_client/period
// - the output channel (out_valid/out_ready) returns one fire item for each
//   table entry whose period divides the step count, in table order, and
//   then one end-of-step item with last set and the registration status
// - a registration computes step count modulo period bit-serially, then writes
//   the new entry
// - the walk reads one entry per cycle from the table ram, except while a
//   fire item waits on the output; each entry keeps a running remainder so
//   no division happens during the walk
// - one item is in work at a time, in_ready is high only between items
// - a stalled receiver holds the walk on the pending fire item; the output
//   register lets the walk go on past entries that do not fire
// - reset clears the step count and empties the table; no clearing pass
module multi_client_periodic_tick_divider_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic [mctd_pkg::CLIENT_W-1:0] new_client,
    input  logic [mctd_pkg::PERIOD_W-1:0] period,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          kind,
    output logic [mctd_pkg::CLIENT_W-1:0] fired_client,
    output logic [mctd_pkg::TICK_W-1:0]   tick_count,
    output logic [1:0]                    status,
    output logic                          last
);

    mctd_pkg::cmd_t  cmd;
    mctd_pkg::stat_t stat;

    mctd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mctd_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_type     (req_type),
        .new_client   (new_client),
        .period       (period),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .fired_client (fired_client),
        .tick_count   (tick_count),
        .status       (status),
        .last         (last),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

/* rtl/core/mctd_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
module mctd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/mctd_ctrl.sv */
// sequencer: accepts a call, runs the registration modulo, walks the table
// and closes the step; depends on mctd_pkg
module mctd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mctd_pkg::stat_t stat,
    output mctd_pkg::cmd_t  cmd
);

    mctd_pkg::state_t state_reg;
    mctd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mctd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            mctd_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.reg_ok)
                    begin
                        cmd.div_init = 1'b1;
                        state_next   = mctd_pkg::S_DIV;
                    end
                    else
                    begin
                        state_next = mctd_pkg::S_FETCH;
                    end
                end
            end
            mctd_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = mctd_pkg::S_INSERT;
                end
            end
            mctd_pkg::S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = mctd_pkg::S_FETCH;
            end
            mctd_pkg::S_FETCH:
            begin
                // first entry read is in flight
                if (stat.table_empty)
                begin
                    state_next = mctd_pkg::S_FINISH;
                end
                else
                begin
                    state_next = mctd_pkg::S_SCAN;
                end
            end
            mctd_pkg::S_SCAN:
            begin
                if (!stat.fire || stat.out_free)
                begin
                    cmd.scan_adv = 1'b1;
                    if (stat.last_entry)
                    begin
                        state_next = mctd_pkg::S_FINISH;
                    end
                end
            end
            mctd_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_end = 1'b1;
                    state_next   = mctd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mctd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/mctd_dp.sv */
// datapath: step counter, table fill count, bit-serial modulo, entry table
// and output register; depends on mctd_pkg and mctd_ram
module mctd_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_type,
    input  logic [mctd_pkg::CLIENT_W-1:0]     new_client,
    input  logic [mctd_pkg::PERIOD_W-1:0]     period,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              kind,
    output logic [mctd_pkg::CLIENT_W-1:0]     fired_client,
    output logic [mctd_pkg::TICK_W-1:0]       tick_count,
    output logic [1:0]                        status,
    output logic                              last,
    input  mctd_pkg::cmd_t                    cmd,
    output mctd_pkg::stat_t                   stat
);

    logic [mctd_pkg::STEP_W-1:0]    step_reg;
    logic [mctd_pkg::CNT_W-1:0]     used_reg;
    logic [mctd_pkg::CNT_W-1:0]     idx_reg;
    logic [mctd_pkg::CLIENT_W-1:0]  client_reg;
    logic [mctd_pkg::PERIOD_W-1:0]  per_reg;
    mctd_pkg::status_t              stat_code_reg;
    mctd_pkg::status_t              stat_code_next;

    logic [mctd_pkg::PERIOD_W-1:0]  div_rem_reg;
    logic [mctd_pkg::STEP_W-1:0]    div_num_reg;
    logic [mctd_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [mctd_pkg::PERIOD_W:0]    div_trial;
    logic [mctd_pkg::PERIOD_W:0]    div_rem_next;

    logic                           out_valid_reg;
    logic                           kind_reg;
    logic [mctd_pkg::CLIENT_W-1:0]  client_out_reg;
    logic [mctd_pkg::TICK_W-1:0]    ticks_out_reg;
    logic [1:0]                     status_out_reg;
    logic                           last_reg;

    mctd_pkg::entry_t               rd_entry;
    mctd_pkg::entry_t               wr_entry;
    logic                           wr_en;
    logic [mctd_pkg::IDX_W-1:0]     wr_addr;
    logic [mctd_pkg::IDX_W-1:0]     rd_addr;
    logic [mctd_pkg::CNT_W-1:0]     idx_inc;
    logic [mctd_pkg::PERIOD_W:0]    rem_inc;
    logic                           step_wrap;
    logic                           out_free;

    always_comb
    begin
        stat_code_next = mctd_pkg::ST_OK;
        if (req_type == mctd_pkg::REQ_REGISTER)
        begin
            if (period == '0)
            begin
                stat_code_next = mctd_pkg::ST_ZERO;
            end
            else if (used_reg == mctd_pkg::CNT_W'(mctd_pkg::TABLE_DEPTH))
            begin
                stat_code_next = mctd_pkg::ST_FULL;
            end
        end
    end

    // restoring remainder, one numerator bit per cycle
    assign div_trial    = {div_rem_reg, div_num_reg[mctd_pkg::STEP_W-1]};
    assign div_rem_next = (div_trial >= {1'b0, per_reg}) ?
                          (div_trial - {1'b0, per_reg}) : div_trial;

    assign out_free  = !out_valid_reg || out_ready;
    assign idx_inc   = idx_reg + 1'b1;
    assign step_wrap = (step_reg == '1);
    assign rem_inc   = {1'b0, rd_entry.rem} + 1'b1;

    always_comb
    begin
        stat.reg_ok      = (req_type == mctd_pkg::REQ_REGISTER) &&
                           (stat_code_next == mctd_pkg::ST_OK);
        stat.div_done    = (div_cnt_reg == '1);
        stat.table_empty = (used_reg == '0);
        stat.last_entry  = (idx_inc == used_reg);
        stat.fire        = (rd_entry.rem == '0);
        stat.out_free    = out_free;
    end

    // table write: new entry on insert, updated entry during the walk
    always_comb
    begin
        wr_en   = cmd.insert || cmd.scan_adv;
        wr_addr = cmd.insert ? used_reg[mctd_pkg::IDX_W-1:0] : idx_reg[mctd_pkg::IDX_W-1:0];
        if (cmd.insert)
        begin
            wr_entry.client = client_reg;
            wr_entry.period = per_reg;
            wr_entry.ticks  = '0;
            wr_entry.rem    = div_rem_reg;
        end
        else
        begin
            wr_entry.client = rd_entry.client;
            wr_entry.period = rd_entry.period;
            wr_entry.ticks  = rd_entry.ticks + mctd_pkg::TICK_W'(stat.fire);
            if (step_wrap || (rem_inc == {1'b0, rd_entry.period}))
            begin
                wr_entry.rem = '0;
            end
            else
            begin
                wr_entry.rem = rem_inc[mctd_pkg::PERIOD_W-1:0];
            end
        end
        rd_addr = cmd.scan_adv ? idx_inc[mctd_pkg::IDX_W-1:0] : idx_reg[mctd_pkg::IDX_W-1:0];
    end

    mctd_ram #(
        .WIDTH (mctd_pkg::ENTRY_W),
        .DEPTH (mctd_pkg::TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            used_reg      <= '0;
            idx_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            stat_code_reg <= mctd_pkg::ST_OK;
        end
        else
        begin
            if (cmd.accept)
            begin
                idx_reg       <= '0;
                stat_code_reg <= stat_code_next;
            end
            else if (cmd.scan_adv)
            begin
                idx_reg <= idx_inc;
            end
            if (cmd.div_init)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cmd.insert)
            begin
                used_reg <= used_reg + 1'b1;
            end
            if (cmd.emit_end)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if ((cmd.scan_adv && stat.fire) || cmd.emit_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            client_reg <= new_client;
            per_reg    <= period;
        end
        if (cmd.div_init)
        begin
            div_rem_reg <= '0;
            div_num_reg <= step_reg;
        end
        else if (cmd.div_step)
        begin
            // remainder stays below the period, so the top bit is always clear
            div_rem_reg <= div_rem_next[mctd_pkg::PERIOD_W-1:0];
            div_num_reg <= {div_num_reg[mctd_pkg::STEP_W-2:0], 1'b0};
        end
        if (cmd.scan_adv && stat.fire)
        begin
            kind_reg       <= mctd_pkg::KIND_FIRE;
            client_out_reg <= rd_entry.client;
            ticks_out_reg  <= rd_entry.ticks;
            status_out_reg <= mctd_pkg::ST_OK;
            last_reg       <= 1'b0;
        end
        else if (cmd.emit_end)
        begin
            kind_reg       <= mctd_pkg::KIND_END;
            client_out_reg <= '0;
            ticks_out_reg  <= '0;
            status_out_reg <= stat_code_reg;
            last_reg       <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign fired_client = client_out_reg;
    assign tick_count   = ticks_out_reg;
    assign status       = status_out_reg;
    assign last         = last_reg;

endmodule

/* tb/multi_client_periodic_tick_divider_unit_tb.sv */
// self-checking testbench of the multi-client periodic tick divider
// needs mctd_pkg and multi_client_periodic_tick_divider_unit; a built-in
// table predictor gives the expected fire and end-of-step items of each call
module multi_client_periodic_tick_divider_unit_tb;

    typedef struct {
        mctd_pkg::kind_t               kind;
        logic [mctd_pkg::CLIENT_W-1:0] client;
        logic [mctd_pkg::TICK_W-1:0]   ticks;
        mctd_pkg::status_t             status;
        logic                          last;
    } tick_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          req_type = 1'b0;
    logic [mctd_pkg::CLIENT_W-1:0] new_client = '0;
    logic [mctd_pkg::PERIOD_W-1:0] period = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          kind;
    logic [mctd_pkg::CLIENT_W-1:0] fired_client;
    logic [mctd_pkg::TICK_W-1:0]   tick_count;
    logic [1:0]                    status;
    logic                          last;

    // predictor state: step counter and the client table
    logic [mctd_pkg::STEP_W-1:0]   step_count_q;
    int                            tbl_used;
    logic [mctd_pkg::CLIENT_W-1:0] tbl_client [mctd_pkg::TABLE_DEPTH];
    logic [mctd_pkg::PERIOD_W-1:0] tbl_period [mctd_pkg::TABLE_DEPTH];
    logic [mctd_pkg::TICK_W-1:0]   tbl_ticks  [mctd_pkg::TABLE_DEPTH];

    tick_result_t expected_tick_results[$];

    int error_count   = 0;
    int hold_request  = 0;
    bit no_idle       = 1'b0;

    multi_client_periodic_tick_divider_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .new_client   (new_client),
        .period       (period),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .fired_client (fired_client),
        .tick_count   (tick_count),
        .status       (status),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_wait();
        if (no_idle)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [mctd_pkg::CLIENT_W-1:0] rand_client();
        logic [31:0] v;
        v = $urandom;
        return v[mctd_pkg::CLIENT_W-1:0];
    endfunction

    // mostly divisors of 12 so steps fire often, some full range, some zero
    function automatic logic [mctd_pkg::PERIOD_W-1:0] rand_period();
        logic [31:0] v;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            v = 0;
        else if (pick <= 2)
            v = $urandom_range(1, 65535);
        else
        begin
            case ($urandom_range(0, 5))
                0: v = 1;
                1: v = 2;
                2: v = 3;
                3: v = 4;
                4: v = 6;
                default: v = 12;
            endcase
        end
        return v[mctd_pkg::PERIOD_W-1:0];
    endfunction

    function automatic void predict_tick_step(mctd_pkg::req_t rq,
                                              logic [mctd_pkg::CLIENT_W-1:0] cli,
                                              logic [mctd_pkg::PERIOD_W-1:0] per);
        mctd_pkg::status_t st;
        tick_result_t      r;
        int                i;
        st = mctd_pkg::ST_OK;
        if (rq == mctd_pkg::REQ_REGISTER)
        begin
            if (per == '0)
                st = mctd_pkg::ST_ZERO;
            else if (tbl_used >= mctd_pkg::TABLE_DEPTH)
                st = mctd_pkg::ST_FULL;
            else
            begin
                tbl_client[tbl_used] = cli;
                tbl_period[tbl_used] = per;
                tbl_ticks[tbl_used]  = '0;
                tbl_used++;
            end
        end
        for (i = 0; i < tbl_used; i++)
        begin
            if (step_count_q % {16'd0, tbl_period[i]} == 0)
            begin
                r = '{mctd_pkg::KIND_FIRE, tbl_client[i], tbl_ticks[i],
                      mctd_pkg::ST_OK, 1'b0};
                expected_tick_results.push_back(r);
                tbl_ticks[i] = tbl_ticks[i] + 1'b1;
            end
        end
        r = '{mctd_pkg::KIND_END, '0, '0, st, 1'b1};
        expected_tick_results.push_back(r);
        step_count_q = step_count_q + 1'b1;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    // valid stays high across back-to-back items; it drops for a gap and in wait_idle
    task automatic issue_call(input mctd_pkg::req_t rq,
                              input logic [mctd_pkg::CLIENT_W-1:0] cli,
                              input logic [mctd_pkg::PERIOD_W-1:0] per);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rq;
        new_client <= cli;
        period     <= per;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        predict_tick_step(rq, cli, per);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_tick_results.size() != 0);
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        tick_result_t want;
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (expected_tick_results.size() == 0)
                flag_mismatch($sformatf("unexpected item kind %0d client %0d ticks %0d",
                                        kind, fired_client, tick_count));
            else
            begin
                want = expected_tick_results.pop_front();
                if (kind !== want.kind)
                    flag_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
                if (fired_client !== want.client)
                    flag_mismatch($sformatf("fired_client %0d, expected %0d",
                                            fired_client, want.client));
                if (tick_count !== want.ticks)
                    flag_mismatch($sformatf("tick_count %0d, expected %0d",
                                            tick_count, want.ticks));
                if (status !== want.status)
                    flag_mismatch($sformatf("status %0d, expected %0d",
                                            status, want.status));
                if (last !== want.last)
                    flag_mismatch($sformatf("last %0d, expected %0d", last, want.last));
            end
        end
    end

    // receiver: random stall per item, or a long hold when asked
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready === 1'b1)
                stall_left = draw_wait();
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // a fresh entry fires in its own step; step 0 divides any period
    task automatic test_fresh_entry();
        issue_call(mctd_pkg::REQ_REGISTER, 8'hFF, 16'hFFFF);
    endtask

    task automatic test_zero_period();
        issue_call(mctd_pkg::REQ_REGISTER, 8'h00, 16'h0000);
        issue_call(mctd_pkg::REQ_REGISTER, rand_client(), 16'h0000);
    endtask

    // a plain call ignores new_client and period
    task automatic test_plain_call();
        issue_call(mctd_pkg::REQ_PLAIN, 8'hFF, 16'hFFFF);
        issue_call(mctd_pkg::REQ_PLAIN, 8'h00, 16'h0000);
    endtask

    task automatic test_small_periods();
        int k;
        issue_call(mctd_pkg::REQ_REGISTER, 8'h00, 16'd1);
        issue_call(mctd_pkg::REQ_REGISTER, 8'h5A, 16'd2);
        issue_call(mctd_pkg::REQ_REGISTER, 8'hA5, 16'd3);
        for (k = 0; k < 5; k++)
            issue_call(mctd_pkg::REQ_PLAIN, rand_client(), rand_period());
    endtask

    task automatic test_random_calls(input int count, input int reg_pct);
        int k;
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < reg_pct)
                issue_call(mctd_pkg::REQ_REGISTER, rand_client(), rand_period());
            else
                issue_call(mctd_pkg::REQ_PLAIN, rand_client(), rand_period());
        end
    endtask

    // zero period is checked before the full table
    task automatic test_table_full();
        while (tbl_used < mctd_pkg::TABLE_DEPTH)
            issue_call(mctd_pkg::REQ_REGISTER, rand_client(), 16'd4);
        issue_call(mctd_pkg::REQ_REGISTER, 8'hFF, 16'hFFFF);
        issue_call(mctd_pkg::REQ_REGISTER, 8'h00, 16'h0000);
        issue_call(mctd_pkg::REQ_PLAIN, rand_client(), rand_period());
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        test_random_calls(30, 20);
        no_idle = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_output_stall();
        wait_idle();
        hold_request = 400;
        no_idle      = 1'b1;
        test_random_calls(20, 20);
        no_idle      = 1'b0;
    endtask

    initial
    begin
        step_count_q = '0;
        tbl_used     = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_fresh_entry();
        test_zero_period();
        test_plain_call();
        test_small_periods();
        test_random_calls(180, 25);
        test_table_full();
        test_back_to_back();
        test_output_stall();
        test_random_calls(180, 20);
        wait_idle();
        repeat (80) @(posedge clk);
        if (error_count == 0)
            $display("[multi_client_periodic_tick_divider_unit] OK");
        else
            $display("[multi_client_periodic_tick_divider_unit] ERROR");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("[multi_client_periodic_tick_divider_unit] ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/core/mctd_pkg.sv
rtl/core/mctd_ram.sv
rtl/core/mctd_ctrl.sv
rtl/core/mctd_dp.sv
rtl/core/multi_client_periodic_tick_divider_unit.sv
tb/multi_client_periodic_tick_divider_unit_tb.sv
